### rtl/ordered_value_list_engine_core_macros.svh
// assertion macros shared by the list engine modules
`ifndef ORDERED_VALUE_LIST_ENGINE_CORE_MACROS_SVH
`define ORDERED_VALUE_LIST_ENGINE_CORE_MACROS_SVH

// property that must hold in every cycle out of reset
`define OVLE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define OVLE_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/ovle_pkg.sv
// shared types and constants of the ordered value list engine
package ovle_pkg;

    localparam int OVLE_CAPACITY   = 64;
    localparam int OVLE_DATA_WIDTH = 32;

    localparam int OVLE_OP_W   = 4;
    localparam int OVLE_VAL_W  = 32;
    localparam int OVLE_POS_W  = 7;
    localparam int OVLE_STAT_W = 2;
    localparam int OVLE_CNT_W  = 7;

    localparam int OVLE_S_TDATA_W = ((OVLE_OP_W + OVLE_VAL_W + OVLE_POS_W + 7) / 8) * 8;
    localparam int OVLE_M_TDATA_W =
        ((OVLE_STAT_W + OVLE_VAL_W + OVLE_POS_W + OVLE_CNT_W + 7) / 8) * 8;

    typedef enum logic [OVLE_OP_W-1:0] {
        OP_APPEND     = 4'd0,
        OP_PREPEND    = 4'd1,
        OP_FIND       = 4'd2,
        OP_INS_AFTER  = 4'd3,
        OP_INS_BEFORE = 4'd4,
        OP_REM_FIRST  = 4'd5,
        OP_REM_LAST   = 4'd6,
        OP_CLEAR      = 4'd7,
        OP_READ       = 4'd8
    } t_op;

    typedef enum logic [OVLE_STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_FAIL = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic [OVLE_CNT_W-1:0]  count;
        logic [OVLE_POS_W-1:0]  match_position;
        logic [OVLE_VAL_W-1:0]  data;
        logic [OVLE_STAT_W-1:0] status;
    } t_result;

endpackage

### rtl/ovle_ctrl.sv
// list sequencer with the entry memory: scan, shift and read-modify-write of entries
`include "ordered_value_list_engine_core_macros.svh"

module ovle_ctrl
    import ovle_pkg::*;
#(
    parameter int CAPACITY   = OVLE_CAPACITY,
    parameter int DATA_WIDTH = OVLE_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [OVLE_OP_W-1:0]         i_op,
    input  logic signed [OVLE_VAL_W-1:0] i_value,
    input  logic [OVLE_POS_W-1:0]        i_position,
    output logic                         o_res_vld,
    input  logic                         i_res_rdy,
    output t_result                      o_res
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > OVLE_POS_W) ? CW : OVLE_POS_W;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_RD_WAIT  = 6'b000010,
        S_SCAN     = 6'b000100,
        S_SHIFT_UP = 6'b001000,
        S_SHIFT_DN = 6'b010000,
        S_FINISH   = 6'b100000
    } t_state;

    logic [DATA_WIDTH-1:0] r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] r_rdata;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_issue, n_issue;
    logic                  r_pend, n_pend;
    t_op                   r_op, n_op;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [AW-1:0]         r_ptr, n_ptr;
    logic [AW-1:0]         r_lim, n_lim;
    logic                  r_dir, n_dir;
    logic [AW-1:0]         r_pend_addr, n_pend_addr;
    t_status               r_status, n_status;
    logic [OVLE_VAL_W-1:0] r_data, n_data;
    logic [OVLE_POS_W-1:0] r_match, n_match;

    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [DATA_WIDTH-1:0] w_wdata;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;

    logic signed [63:0]    w_val_ext;
    logic [DATA_WIDTH-1:0] w_val;
    logic signed [63:0]    w_rd_ext;
    logic [CMPW-1:0]       w_pos_ext;
    logic [CMPW-1:0]       w_cnt_ext;
    logic [CMPW-1:0]       w_idx;
    logic                  w_full;
    logic                  w_pos_ok;
    logic                  w_last;
    logic [AW-1:0]         w_nxt_ptr;
    logic                  w_hit;

    assign w_val_ext = 64'(i_value);
    assign w_val     = w_val_ext[DATA_WIDTH-1:0];
    assign w_rd_ext  = 64'($signed(r_rdata));
    assign w_pos_ext = CMPW'(i_position);
    assign w_cnt_ext = CMPW'(r_cnt);
    assign w_full    = (r_cnt == CW'(CAPACITY));
    assign w_pos_ok  = (w_pos_ext != '0) && (w_pos_ext <= w_cnt_ext);
    assign w_last    = (r_ptr == r_lim);
    assign w_nxt_ptr = r_dir ? AW'(r_ptr - AW'(1)) : AW'(r_ptr + AW'(1));
    assign w_hit     = r_pend && (r_rdata == r_val);

    always_comb begin
        case (i_op)
            OP_INS_AFTER:  w_idx = w_pos_ext;
            OP_INS_BEFORE: w_idx = CMPW'(w_pos_ext - CMPW'(1));
            default:       w_idx = '0;
        endcase
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_issue     = r_issue;
        n_pend      = r_pend;
        n_op        = r_op;
        n_val       = r_val;
        n_ptr       = r_ptr;
        n_lim       = r_lim;
        n_dir       = r_dir;
        n_pend_addr = r_pend_addr;
        n_status    = r_status;
        n_data      = r_data;
        n_match     = r_match;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = '0;
        w_re        = 1'b0;
        w_raddr     = r_ptr;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op     = t_op'(i_op);
                    n_val    = w_val;
                    n_data   = '0;
                    n_match  = '0;
                    n_status = ST_FAIL;
                    n_pend   = 1'b0;
                    n_state  = S_FINISH;
                    case (i_op)
                        OP_APPEND: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                w_we     = 1'b1;
                                w_waddr  = AW'(r_cnt);
                                w_wdata  = w_val;
                                n_cnt    = CW'(r_cnt + CW'(1));
                                n_status = ST_OK;
                            end
                        end
                        OP_PREPEND, OP_INS_AFTER, OP_INS_BEFORE: begin
                            if ((i_op != OP_PREPEND) && !w_pos_ok) begin
                                n_status = ST_FAIL;
                            end else if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_lim   = AW'(w_idx);
                                n_ptr   = AW'(r_cnt - CW'(1));
                                n_issue = (w_idx != w_cnt_ext);
                                n_dir   = 1'b1;
                                n_state = S_SHIFT_UP;
                            end
                        end
                        OP_FIND, OP_REM_FIRST: begin
                            if (r_cnt != '0) begin
                                n_ptr   = '0;
                                n_lim   = AW'(r_cnt - CW'(1));
                                n_dir   = 1'b0;
                                n_issue = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        OP_REM_LAST: begin
                            if (r_cnt != '0) begin
                                n_ptr   = AW'(r_cnt - CW'(1));
                                n_lim   = '0;
                                n_dir   = 1'b1;
                                n_issue = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        OP_CLEAR: begin
                            n_cnt    = '0;
                            n_status = ST_OK;
                        end
                        OP_READ: begin
                            if (w_pos_ok) begin
                                w_re    = 1'b1;
                                w_raddr = AW'(w_pos_ext - CMPW'(1));
                                n_state = S_RD_WAIT;
                            end
                        end
                        default: begin
                            n_status = ST_FAIL;
                        end
                    endcase
                end
            end
            S_RD_WAIT: begin
                n_data   = w_rd_ext[OVLE_VAL_W-1:0];
                n_status = ST_OK;
                n_state  = S_FINISH;
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_status = ST_OK;
                    n_pend   = 1'b0;
                    n_issue  = 1'b0;
                    if (r_op == OP_FIND) begin
                        n_match = OVLE_POS_W'({1'b0, r_pend_addr} + (AW + 1)'(1));
                        n_state = S_FINISH;
                    end else if ((CW'(r_pend_addr) + CW'(1)) == r_cnt) begin
                        n_cnt   = CW'(r_cnt - CW'(1));
                        n_state = S_FINISH;
                    end else begin
                        n_ptr   = AW'(r_pend_addr + AW'(1));
                        n_lim   = AW'(r_cnt - CW'(1));
                        n_dir   = 1'b0;
                        n_issue = 1'b1;
                        n_state = S_SHIFT_DN;
                    end
                end else if (!r_issue && !r_pend) begin
                    n_status = ST_FAIL;
                    n_state  = S_FINISH;
                end else if (r_issue) begin
                    w_re        = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_ptr;
                    if (w_last) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = w_nxt_ptr;
                    end
                end else begin
                    n_pend = 1'b0;
                end
            end
            S_SHIFT_UP, S_SHIFT_DN: begin
                if (r_pend) begin
                    w_we    = 1'b1;
                    w_wdata = r_rdata;
                    w_waddr = (r_state == S_SHIFT_UP) ? AW'(r_pend_addr + AW'(1))
                                                      : AW'(r_pend_addr - AW'(1));
                end
                if (r_issue) begin
                    w_re        = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_addr = r_ptr;
                    if (w_last) begin
                        n_issue = 1'b0;
                    end else begin
                        n_ptr = w_nxt_ptr;
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (!r_issue && !r_pend) begin
                    n_state = S_FINISH;
                    if (r_state == S_SHIFT_UP) begin
                        w_we     = 1'b1;
                        w_waddr  = r_lim;
                        w_wdata  = r_val;
                        n_cnt    = CW'(r_cnt + CW'(1));
                        n_status = ST_OK;
                    end else begin
                        n_cnt = CW'(r_cnt - CW'(1));
                    end
                end
            end
            S_FINISH: begin
                if (i_res_rdy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_issue <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_issue <= n_issue;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_val       <= n_val;
        r_ptr       <= n_ptr;
        r_lim       <= n_lim;
        r_dir       <= n_dir;
        r_pend_addr <= n_pend_addr;
        r_status    <= n_status;
        r_data      <= n_data;
        r_match     <= n_match;
    end

    assign o_ready              = (r_state == S_IDLE);
    assign o_res_vld            = (r_state == S_FINISH);
    assign o_res.status         = r_status;
    assign o_res.data           = r_data;
    assign o_res.match_position = r_match;
    assign o_res.count          = OVLE_CNT_W'(r_cnt);

    `OVLE_ASSERT(a_cnt_bound, r_cnt <= CW'(CAPACITY), "entry count above capacity")
    `OVLE_ASSERT(a_no_rw_clash, w_we && w_re |-> w_waddr != w_raddr, "read and write hit one entry")
    `OVLE_ASSERT(a_write_in_list, w_we |-> CW'(w_waddr) <= r_cnt, "write beyond end of list")
    `OVLE_ASSERT(a_full_means_full, (r_state == S_FINISH) && (r_status == ST_FULL) |-> w_full, "full status on a list with room")

endmodule

### rtl/ordered_value_list_engine_core.sv
// top level of the ordered value list engine: stream ports and output register
//
// A bounded ordered list of signed values, held in one on-chip memory.
// Input channel s_axis: one transfer is one operation (append, prepend, find,
// insert after or before a position, remove first or last match, clear, read).
// Output channel m_axis: exactly one result transfer per operation, in order.
// Operations run one at a time; s_axis_tready drops while one is in progress
// and rises again as soon as its result has moved to the output register.
// Append, clear and any rejected operation finish straight away; a read waits
// for the registered memory read; an insert moves the entries from its
// position on up by one, then writes the value; find scans until a match;
// a remove searches, then closes the gap (a remove last that matches the
// first entry pays both passes in full).
// The entry memory, with one write and one registered read port, moves or
// compares one entry per cycle.
// A finished result sits in the output register; the next operation is taken
// while it waits, and only its own completion stalls on a held-off receiver.
// Reset empties the list at once; entry contents are not cleared.
`include "ordered_value_list_engine_core_macros.svh"

module ordered_value_list_engine_core
    import ovle_pkg::*;
#(
    parameter int CAPACITY   = OVLE_CAPACITY,
    parameter int DATA_WIDTH = OVLE_DATA_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    // op[3:0], value[35:4], position[42:36], zero[47:43]
    input  logic [OVLE_S_TDATA_W-1:0] s_axis_tdata,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // status[1:0], data[33:2], match_position[40:34], count[47:41]
    output logic [OVLE_M_TDATA_W-1:0] m_axis_tdata
);

    logic    w_res_vld;
    logic    w_res_rdy;
    t_result w_res;

    logic    r_out_vld, n_out_vld;
    t_result r_out;

    ovle_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_op       (s_axis_tdata[OVLE_OP_W-1:0]),
        .i_value    ($signed(s_axis_tdata[OVLE_OP_W +: OVLE_VAL_W])),
        .i_position (s_axis_tdata[OVLE_OP_W + OVLE_VAL_W +: OVLE_POS_W]),
        .o_res_vld  (w_res_vld),
        .i_res_rdy  (w_res_rdy),
        .o_res      (w_res)
    );

    assign w_res_rdy = !r_out_vld || m_axis_tready;

    always_comb begin
        n_out_vld = r_out_vld;
        if (w_res_vld && w_res_rdy) begin
            n_out_vld = 1'b1;
        end else if (m_axis_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_vld && w_res_rdy) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OVLE_M_TDATA_W'(r_out);

    `OVLE_ASSERT_NEXT(a_res_lands, w_res_vld && w_res_rdy, m_axis_tvalid, "result transfer lost")
    `OVLE_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "overlap")

endmodule
